// ===== hdl/wmn_pkg.sv =====
// Shared types and constants for the window maximum normalizer.
// Used by the register block, controller, datapath and top level; no dependencies.
package wmn_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned QBITS    = 7;
  // A sample times 100 needs seven more bits than the sample.
  localparam int unsigned PROD_W   = SAMPLE_W + QBITS;
  localparam int unsigned STEP_W   = 3;

  localparam logic [PCT_W-1:0]    PERCENT_FULL      = 7'd100;
  localparam logic [SAMPLE_W-1:0] SCALE_FLOOR_RESET = 32'd100;

  localparam int unsigned PADDR_W = 3;
  // Register index sits in paddr[2]; index 0 is scale_floor.
  localparam logic REG_SCALE_FLOOR = 1'b0;

  typedef struct packed {
    logic              wr;         // write accepted sample, advance head
    logic              rd;         // read history at the read pointer
    logic              max_clear;  // load the running maximum with the floor
    logic              max_acc;    // fold the read data into the maximum
    logic              max_fin;    // force a zero divisor to one
    logic              mul_load;   // scale the read data by 100
    logic              div_step;   // one restoring division step
    logic [STEP_W-1:0] qbit;       // quotient bit worked on by div_step
    logic              out_load;   // load the output register
    logic [IDX_W-1:0]  idx;        // window position of the loaded point
    logic              last;       // newest point flag
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being emptied this cycle
  } status_t;

endpackage

// ===== hdl/wmn_if.sv =====
// Valid/ready channel interfaces for samples in and normalized points out.
// Widths come from wmn_pkg.
interface wmn_sample_if;
  logic                         valid;
  logic                         ready;
  logic [wmn_pkg::SAMPLE_W-1:0] new_sample;

  modport source (output valid, output new_sample, input ready);
  modport sink   (input valid, input new_sample, output ready);
endinterface

interface wmn_point_if;
  logic                      valid;
  logic                      ready;
  logic [wmn_pkg::IDX_W-1:0] point_index;
  logic [wmn_pkg::PCT_W-1:0] percent;
  logic                      last_point;

  modport source (output valid, output point_index, output percent, output last_point,
                  input ready);
  modport sink   (input valid, input point_index, input percent, input last_point,
                  output ready);
endinterface

// ===== hdl/wmn_regs.sv =====
// APB-style configuration register block holding scale_floor.
// Depends on wmn_pkg for widths, reset value and register decode.
module wmn_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wmn_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [wmn_pkg::SAMPLE_W-1:0] scale_floor
);

  logic hit;

  assign hit    = (paddr[2] == wmn_pkg::REG_SCALE_FLOOR);
  assign pready = 1'b1;
  assign prdata = hit ? scale_floor : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_floor <= wmn_pkg::SCALE_FLOOR_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      scale_floor <= pwdata;
    end
  end

endmodule

// ===== hdl/wmn_ctrl.sv =====
// Sequencer for the normalizer: accept, maximum pass, then read, scale,
// divide and emit for each window position. Depends on wmn_pkg.
module wmn_ctrl #(
  parameter int unsigned WINDOW = 60
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wmn_pkg::status_t status,
  output wmn_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAX  = 8'b0000_0010,
    S_MAXW = 8'b0000_0100,
    S_FIN  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  localparam logic [wmn_pkg::IDX_W-1:0] LAST_IDX = wmn_pkg::IDX_W'(WINDOW - 1);

  state_t                       state, state_next;
  logic [wmn_pkg::IDX_W-1:0]    k, k_next;
  logic [wmn_pkg::STEP_W-1:0]   step, step_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    k_next     = k;
    step_next  = step;
    cmd        = '0;
    cmd.qbit   = step;
    cmd.idx    = k;
    cmd.last   = (k == LAST_IDX);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr        = 1'b1;
          cmd.max_clear = 1'b1;
          k_next        = '0;
          state_next    = S_MAX;
        end
      end
      S_MAX: begin
        cmd.rd = 1'b1;
        // Read data arrives in the cycle after the address.
        cmd.max_acc = (k != '0);
        if (k == LAST_IDX) begin
          state_next = S_MAXW;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_MAXW: begin
        cmd.max_acc = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        cmd.max_fin = 1'b1;
        k_next      = '0;
        state_next  = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        step_next    = wmn_pkg::STEP_W'(wmn_pkg::QBITS - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == '0) begin
          state_next = S_EMIT;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (k == LAST_IDX) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      step  <= step_next;
    end
  end

endmodule

// ===== hdl/wmn_dp.sv =====
// Datapath: circular sample history memory, running maximum, x100 scaling,
// restoring divider and output register. Depends on wmn_pkg; driven by wmn_ctrl.
module wmn_dp #(
  parameter int unsigned WINDOW = 60
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wmn_pkg::SAMPLE_W-1:0] new_sample,
  input  logic [wmn_pkg::SAMPLE_W-1:0] scale_floor,
  input  wmn_pkg::cmd_t                cmd,
  output wmn_pkg::status_t             status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wmn_pkg::IDX_W-1:0]    point_index,
  output logic [wmn_pkg::PCT_W-1:0]    percent,
  output logic                         last_point
);

  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [wmn_pkg::SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]            vld;
  logic [wmn_pkg::SAMPLE_W-1:0] mem_q;
  logic                         vld_q;
  logic [wmn_pkg::SAMPLE_W-1:0] rd_val;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_inc;

  logic [wmn_pkg::SAMPLE_W-1:0] acc;
  logic [wmn_pkg::PROD_W-1:0]   rem;
  logic [wmn_pkg::PROD_W-1:0]   trial;
  logic [wmn_pkg::QBITS-1:0]    quo;
  logic [wmn_pkg::PCT_W-1:0]    pct;

  assign head_next  = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;

  // Entries never written since reset read as zero.
  assign rd_val = vld_q ? mem_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[head] <= new_sample;
    end
    if (cmd.rd) begin
      mem_q <= mem[rd_ptr];
      vld_q <= vld[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      head   <= '0;
      rd_ptr <= '0;
    end else if (cmd.wr) begin
      vld[head] <= 1'b1;
      head      <= head_next;
      // The new head is the oldest entry: reads start there.
      rd_ptr    <= head_next;
    end else if (cmd.rd) begin
      rd_ptr <= rd_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.max_clear) begin
      acc <= scale_floor;
    end else if (cmd.max_acc) begin
      if (rd_val > acc) begin
        acc <= rd_val;
      end
    end else if (cmd.max_fin) begin
      if (acc == '0) begin
        acc <= wmn_pkg::SAMPLE_W'(1);
      end
    end
  end

  assign trial = wmn_pkg::PROD_W'(acc) << cmd.qbit;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      rem <= wmn_pkg::PROD_W'(rd_val) * wmn_pkg::PROD_W'(wmn_pkg::PERCENT_FULL);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= trial) begin
        rem            <= rem - trial;
        quo[cmd.qbit]  <= 1'b1;
      end
    end
  end

  assign pct = (quo > wmn_pkg::PERCENT_FULL) ? wmn_pkg::PERCENT_FULL : quo;

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_index <= cmd.idx;
      percent     <= pct;
      last_point  <= cmd.last;
    end
  end

endmodule

// ===== hdl/window_max_normalizer_core.sv =====
// Top level of the window maximum normalizer: register block, controller and datapath.
// Depends on wmn_pkg, wmn_if, wmn_regs, wmn_ctrl and wmn_dp.
//
//   channel  | dir | beat payload                          | handshake
//   ---------+-----+---------------------------------------+---------------------
//   samples  | in  | new_sample[31:0]                      | valid/ready
//   points   | out | point_index[5:0] percent[6:0] last    | valid/ready
//   apb      | in  | paddr[2:0] pwdata[31:0] -> prdata     | psel/penable, pready=1
//
// Each sample beat produces WINDOW point beats: one history read per cycle for the
// maximum, then per point a read, a x100 scale and seven divider steps, one
// quotient bit per cycle. The output register lets the next sample be taken
// while the last point still waits. Reset clears the history valid bits at once
// and sets scale_floor to 100. An output stall holds the sequencer in its emit step.
module window_max_normalizer_core #(
  parameter int unsigned WINDOW = 60
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wmn_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  wmn_sample_if.sink                  samples,
  wmn_point_if.source                 points
);

  logic [wmn_pkg::SAMPLE_W-1:0] scale_floor;
  wmn_pkg::cmd_t                cmd;
  wmn_pkg::status_t             status;

  wmn_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .scale_floor (scale_floor)
  );

  wmn_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmn_dp #(.WINDOW(WINDOW)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .new_sample  (samples.new_sample),
    .scale_floor (scale_floor),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (points.valid),
    .out_ready   (points.ready),
    .point_index (points.point_index),
    .percent     (points.percent),
    .last_point  (points.last_point)
  );

endmodule

// ===== hdl/wmn_checker.sv =====
// Port-level checks for window_max_normalizer_core, attached with bind.
// Depends on wmn_pkg for field widths and the full-scale constant.
module wmn_checker #(
  parameter int unsigned WINDOW = 60
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_valid,
  input logic                      s_ready,
  input logic                      p_valid,
  input logic                      p_ready,
  input logic [wmn_pkg::IDX_W-1:0] p_index,
  input logic [wmn_pkg::PCT_W-1:0] p_percent,
  input logic                      p_last
);

  // A stalled point beat keeps its valid and payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_ready |=> p_valid && $stable(p_index) && $stable(p_percent)
                            && $stable(p_last))
    else $error("point beat changed while stalled");

  // A sample starts a long run, so the next sample cannot follow at once.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> !s_ready)
    else $error("sample taken back to back");

  a_last: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (p_last == (p_index == wmn_pkg::IDX_W'(WINDOW - 1))))
    else $error("last flag not on the newest point");

  a_pct: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> p_percent <= wmn_pkg::PERCENT_FULL)
    else $error("percent above full scale");

endmodule

bind window_max_normalizer_core wmn_checker #(.WINDOW(WINDOW)) u_wmn_checker (
  .clk       (clk),
  .rst       (rst),
  .s_valid   (samples.valid),
  .s_ready   (samples.ready),
  .p_valid   (points.valid),
  .p_ready   (points.ready),
  .p_index   (points.point_index),
  .p_percent (points.percent),
  .p_last    (points.last_point)
);

// ===== sim/window_max_normalizer_core_tb.sv =====
// Self-checking testbench for window_max_normalizer_core: drives sample beats,
// writes scale_floor over APB and checks every point beat against a local predictor.
// Depends on wmn_pkg, wmn_if and the RTL of the block.
module window_max_normalizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN          = 60;
  localparam int unsigned N_PHASES     = 7;
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;

  localparam logic [wmn_pkg::PADDR_W-1:0] ADDR_SCALE_FLOOR =
    {wmn_pkg::REG_SCALE_FLOOR, 2'b00};
  localparam logic [wmn_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
    {~wmn_pkg::REG_SCALE_FLOOR, 2'b00};

  typedef struct packed {
    logic [wmn_pkg::IDX_W-1:0] point_index;
    logic [wmn_pkg::PCT_W-1:0] percent;
    logic                      last_point;
  } point_t;

  // One directed row: optional floor change first, then one sample, and where
  // the newest percent is obvious, that value typed in.
  typedef struct packed {
    logic                         set_floor;
    logic [wmn_pkg::SAMPLE_W-1:0] floor_val;
    logic [wmn_pkg::SAMPLE_W-1:0] sample;
    logic                         chk;
    logic [wmn_pkg::PCT_W-1:0]    pct;
  } dir_row_t;

  localparam int unsigned N_DIR = 18;
  dir_row_t dir_rows [N_DIR] = '{
    // Zero floor right after reset: all-zero window forces the divisor to one.
    '{1'b1, 32'd0,          32'd0,          1'b1, 7'd0},
    '{1'b0, 32'd0,          32'd0,          1'b1, 7'd0},
    '{1'b0, 32'd0,          32'd7,          1'b1, 7'd100},
    '{1'b0, 32'd0,          32'd3,          1'b1, 7'd42},
    '{1'b1, 32'd1,          32'd1,          1'b1, 7'd14},
    '{1'b1, 32'd100,        32'd100,        1'b1, 7'd100},
    '{1'b0, 32'd0,          32'd50,         1'b1, 7'd50},
    '{1'b0, 32'd0,          32'd250,        1'b1, 7'd100},
    '{1'b0, 32'd0,          32'd25,         1'b1, 7'd10},
    '{1'b1, 32'd1000,       32'd500,        1'b1, 7'd50},
    '{1'b0, 32'd0,          32'd999,        1'b1, 7'd99},
    '{1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 7'd100},
    '{1'b0, 32'd0,          32'h8000_0000,  1'b1, 7'd50},
    '{1'b0, 32'd0,          32'd0,          1'b1, 7'd0},
    '{1'b1, 32'd1,          32'hFFFF_FFFE,  1'b1, 7'd99},
    '{1'b0, 32'd0,          32'd1,          1'b1, 7'd0},
    '{1'b0, 32'd0,          32'h5555_5555,  1'b1, 7'd33},
    '{1'b0, 32'd0,          32'hAAAA_AAAA,  1'b1, 7'd66}
  };

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [wmn_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  wmn_sample_if sample_ch();
  wmn_point_if  point_ch();

  window_max_normalizer_core #(.WINDOW(WIN)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (sample_ch),
    .points  (point_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [wmn_pkg::SAMPLE_W-1:0] hist_m [WIN];
  logic [wmn_pkg::SAMPLE_W-1:0] floor_m;
  point_t                       point_q [$];

  int unsigned errors     = 0;
  int unsigned n_samples  = 0;
  int unsigned n_points   = 0;
  int unsigned n_settings = 0;
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  bit          hold_req   = 1'b0;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at point beat %0d: %s got %0d want %0d", n_points, what, got, want);
    errors++;
  endtask

  // Slide the window, then queue one expected point per window position.
  task automatic predict_window(input logic [wmn_pkg::SAMPLE_W-1:0] s);
    logic [63:0] divisor;
    logic [63:0] pct;
    point_t      p;
    for (int k = 0; k < WIN - 1; k++) hist_m[k] = hist_m[k + 1];
    hist_m[WIN - 1] = s;
    divisor = {32'd0, floor_m};
    for (int k = 0; k < WIN; k++) begin
      if ({32'd0, hist_m[k]} > divisor) divisor = {32'd0, hist_m[k]};
    end
    if (divisor == 64'd0) divisor = 64'd1;
    for (int k = 0; k < WIN; k++) begin
      pct = ({32'd0, hist_m[k]} * 64'd100) / divisor;
      if (pct > 64'(wmn_pkg::PERCENT_FULL)) pct = 64'(wmn_pkg::PERCENT_FULL);
      p.point_index = k[wmn_pkg::IDX_W-1:0];
      p.percent     = pct[wmn_pkg::PCT_W-1:0];
      p.last_point  = (k == WIN - 1);
      point_q.push_back(p);
    end
  endtask

  // Offer one sample beat, after an optional idle burst; valid stays high on return.
  task automatic send_sample(input logic [wmn_pkg::SAMPLE_W-1:0] s);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.new_sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    n_samples++;
    predict_window(s);
  endtask

  task automatic drain_points();
    sample_ch.valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
  endtask

  // One APB transfer, then psel dropped and the bus left idle.
  task automatic apb_access(input logic wr, input logic [wmn_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_register(input logic [wmn_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, addr, val, rd);
    if (addr == ADDR_SCALE_FLOOR) begin
      floor_m = val;
      n_settings++;
    end
    apb_access(1'b0, ADDR_SCALE_FLOOR, 32'd0, rd);
    if (rd !== floor_m) flag_mismatch("scale_floor readback", rd, floor_m);
  endtask

  // Half of the samples share one magnitude per phase, so percents spread out;
  // the rest are zeros, all ones, small values and full-range noise.
  function automatic logic [wmn_pkg::SAMPLE_W-1:0] rand_sample(input int unsigned shift);
    case ($urandom_range(0, 9)) inside
      0:       return $urandom;
      1:       return '0;
      2:       return '1;
      [3:4]:   return $urandom_range(0, 300);
      default: return $urandom >> shift;
    endcase
  endfunction

  // Point side: compare every accepted beat, then choose ready for the next edge.
  int unsigned hold_left = 0;
  int unsigned idle_left = 0;
  always @(posedge clk) begin : rx_side
    point_t want;
    if (point_ch.valid && point_ch.ready) begin
      if (point_q.size() == 0) begin
        flag_mismatch("unexpected point, index", point_ch.point_index, -1);
      end else begin
        want = point_q.pop_front();
        if (point_ch.point_index !== want.point_index)
          flag_mismatch("point_index", point_ch.point_index, want.point_index);
        if (point_ch.percent !== want.percent)
          flag_mismatch("percent", point_ch.percent, want.percent);
        if (point_ch.last_point !== want.last_point)
          flag_mismatch("last_point", point_ch.last_point, want.last_point);
      end
      n_points++;
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      point_ch.ready <= 1'b0;
    end else if (idle_left != 0) begin
      idle_left--;
      point_ch.ready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      idle_left = $urandom_range(1, 18) - 1;
      point_ch.ready <= 1'b0;
    end else begin
      point_ch.ready <= 1'b1;
    end
  end

  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (point_ch.valid && point_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : main
    logic [wmn_pkg::SAMPLE_W-1:0] floors [N_PHASES];
    logic [31:0]                  rd;
    int unsigned                  shift;

    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.new_sample <= '0;
    for (int k = 0; k < WIN; k++) hist_m[k] = '0;
    floor_m = wmn_pkg::SCALE_FLOOR_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_access(1'b0, ADDR_SCALE_FLOOR, 32'd0, rd);
    if (rd !== wmn_pkg::SCALE_FLOOR_RESET)
      flag_mismatch("scale_floor after reset", rd, wmn_pkg::SCALE_FLOOR_RESET);
    // A write to an unmapped index must leave scale_floor alone.
    set_register(ADDR_UNMAPPED, 32'hDEAD_BEEF);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_floor) begin
        drain_points();
        set_register(ADDR_SCALE_FLOOR, dir_rows[i].floor_val);
      end
      send_sample(dir_rows[i].sample);
      if (dir_rows[i].chk) point_q[point_q.size() - 1].percent = dir_rows[i].pct;
    end

    floors[0] = wmn_pkg::SCALE_FLOOR_RESET;
    floors[1] = $urandom_range(1, 5000);
    floors[2] = '0;
    floors[3] = 32'd1;
    floors[4] = '1;
    floors[5] = $urandom;
    floors[6] = $urandom_range(50, 400);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_points();
      if (ph == 3) set_register(ADDR_UNMAPPED, $urandom);
      set_register(ADDR_SCALE_FLOOR, floors[ph]);
      shift = $urandom_range(0, 28);
      if (ph == N_PHASES - 1) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      // The output side stops for a long stretch while samples keep coming.
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) drain_points();
        send_sample(rand_sample(shift));
      end
    end

    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d point beats from %0d samples across %0d scale_floor settings,",
             n_points, n_samples, n_settings);
    $display("including floors of zero, one and all ones, a long output hold and drains.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
